>>> rtl/c3s_pkg.sv
// ----------------------------------------------------------------------------
// c3s_pkg: shared types and constants of the 3x3 Cramer solver
// Widths, divider stage count and the context carried along the divider chain.
// ----------------------------------------------------------------------------
package c3s_pkg;

  localparam int unsigned CoefW  = 16;
  localparam int unsigned MinorW = 33;   // product difference of two Q7.8 pairs
  localparam int unsigned DetW   = 50;   // three 49-bit terms summed
  localparam int unsigned MagW   = 48;   // determinant magnitudes stay below 2^48
  localparam int unsigned NumW   = MagW + 16;
  localparam int unsigned QW     = NumW; // quotient width
  localparam int unsigned SolW   = 32;
  localparam int unsigned Stages = NumW; // one quotient bit per cell
  localparam int unsigned InW    = 12 * CoefW;
  localparam int unsigned OutW   = 3 * SolW;

  localparam logic [QW-1:0] MaxPos = QW'(64'h0000_0000_7FFF_FFFF);
  localparam logic [QW-1:0] MaxNeg = QW'(64'h0000_0000_8000_0000);

  typedef struct packed {
    logic singular;
    logic [2:0] neg;
  } c3s_ctx_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [MagW:0]   rem;
    logic [NumW-1:0] num;   // numerator bits still to shift in, MSB first
    logic [QW-1:0]   quo;
  } c3s_lane_t;

  typedef struct packed {
    logic [MagW-1:0] den;
    c3s_ctx_t        ctx;
    c3s_lane_t [2:0] lane;
  } c3s_cell_t;

endpackage

>>> rtl/cramer_3x3_linear_solver.sv
// ----------------------------------------------------------------------------
// cramer_3x3_linear_solver: 3x3 linear system solver by Cramer's rule
// Determinants in two stages, a chain of 64 divider cells, then a sat stage.
// ----------------------------------------------------------------------------
// An item passes the det stages, the divider cells and the output register in turn.
// Throughput: one item per cycle unless stalled; the 64-cell divider chain holds one item per cell.
// Backpressure stalls the whole pipeline when the output register is full and
// not taken; in_tready follows out_tready or an empty output slot.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
module cramer_3x3_linear_solver (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // a_x_row0..2, a_y_row0..2, a_z_row0..2, rhs_row0..2 (16 bits each, low up)
  input  logic [c3s_pkg::InW-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // sol_x, sol_y, sol_z (32 bits each, low up)
  output logic [c3s_pkg::OutW-1:0] out_tdata,
  // singular, saturated
  output logic [1:0]               out_tuser
);
  import c3s_pkg::*;

  logic      en;
  logic      vld [Stages+1];
  c3s_cell_t chain [Stages+1];
  logic      ovld_r;
  logic [OutW-1:0] odata_r, odata_nxt;
  logic [1:0] ouser_r, ouser_nxt;

  // whole pipe advances unless the output slot is full and stalled
  assign en        = !ovld_r || out_tready;
  assign in_tready = en;

  c3s_det u_det (
    .clk, .rst_n, .en,
    .in_vld  (in_tvalid),
    .in_data (in_tdata),
    .out_vld (vld[0]),
    .out_cell(chain[0])
  );

  for (genvar g = 0; g < Stages; g++) begin : g_div
    c3s_div_cell u_cell (
      .clk, .rst_n, .en,
      .in_vld  (vld[g]),
      .in_cell (chain[g]),
      .out_vld (vld[g+1]),
      .out_cell(chain[g+1])
    );
  end

  // sign, saturation and singular override
  always_comb begin
    logic [QW-1:0] q;
    logic sat;
    sat = 1'b0;
    odata_nxt = '0;
    for (int l = 0; l < 3; l++) begin
      q = chain[Stages].lane[l].quo;
      if (chain[Stages].ctx.neg[l]) begin
        if (q > MaxNeg) begin
          q = MaxNeg;
          sat = 1'b1;
        end
        q = -q;
      end else if (q > MaxPos) begin
        q = MaxPos;
        sat = 1'b1;
      end
      odata_nxt[l*SolW +: SolW] = q[SolW-1:0];
    end
    if (chain[Stages].ctx.singular) begin
      odata_nxt = '0;
      sat = 1'b0;
    end
    ouser_nxt = {sat, chain[Stages].ctx.singular};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      odata_r <= odata_nxt;
      ouser_r <= ouser_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (en) ovld_r <= vld[Stages];
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !ovld_r |-> in_tready) else $error("ready low with empty output");
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("singular result not cleared");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
`endif

endmodule

>>> rtl/c3s_det.sv
// ----------------------------------------------------------------------------
// c3s_det: determinant front end
// Two registered stages: 2x2 minors, then the four 3x3 determinants as magnitudes.
// ----------------------------------------------------------------------------
module c3s_det (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [c3s_pkg::InW-1:0]  in_data,
  output logic                     out_vld,
  output c3s_pkg::c3s_cell_t       out_cell
);
  import c3s_pkg::*;

  logic signed [CoefW-1:0] c [4][3];  // columns x, y, z, rhs
  logic signed [MinorW-1:0] m_yz_r [3], m_rz_r [3], m_yr_r [3];
  logic signed [CoefW-1:0]  cx_r [3], cr_r [3];
  logic vld1_r, vld2_r;
  c3s_cell_t cell_r, cell_nxt;
  logic signed [DetW-1:0] d, dx, dy, dz;

  always_comb begin
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 3; i++)
        c[k][i] = in_data[(3*k+i)*CoefW +: CoefW];
  end

  function automatic logic signed [MinorW-1:0] mnr(
    input logic signed [CoefW-1:0] a0, a1, a2, b0, b1, b2, input int unsigned j);
    logic signed [MinorW-1:0] r;
    begin
      r = '0;
      case (j)
        0: r = MinorW'(a1) * MinorW'(b2) - MinorW'(a2) * MinorW'(b1);
        1: r = MinorW'(a2) * MinorW'(b0) - MinorW'(a0) * MinorW'(b2);
        default: r = MinorW'(a0) * MinorW'(b1) - MinorW'(a1) * MinorW'(b0);
      endcase
      return r;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        m_yz_r[j] <= mnr(c[1][0], c[1][1], c[1][2], c[2][0], c[2][1], c[2][2], j);
        m_rz_r[j] <= mnr(c[3][0], c[3][1], c[3][2], c[2][0], c[2][1], c[2][2], j);
        m_yr_r[j] <= mnr(c[1][0], c[1][1], c[1][2], c[3][0], c[3][1], c[3][2], j);
        cx_r[j] <= c[0][j];
        cr_r[j] <= c[3][j];
      end
      cell_r <= cell_nxt;
    end
  end

  function automatic logic [MagW-1:0] mag(input logic signed [DetW-1:0] v);
    logic [DetW-1:0] a;
    begin
      a = v[DetW-1] ? DetW'(-v) : DetW'(v);
      return a[MagW-1:0];
    end
  endfunction

  always_comb begin
    d = '0; dx = '0; dy = '0; dz = '0;
    for (int j = 0; j < 3; j++) begin
      d  = d  + DetW'(cx_r[j]) * DetW'(m_yz_r[j]);
      dx = dx + DetW'(cr_r[j]) * DetW'(m_yz_r[j]);
      dy = dy + DetW'(cx_r[j]) * DetW'(m_rz_r[j]);
      dz = dz + DetW'(cx_r[j]) * DetW'(m_yr_r[j]);
    end
    cell_nxt.den          = mag(d);
    cell_nxt.ctx.singular = (d == '0);
    cell_nxt.ctx.neg[0]   = dx[DetW-1] ^ d[DetW-1];
    cell_nxt.ctx.neg[1]   = dy[DetW-1] ^ d[DetW-1];
    cell_nxt.ctx.neg[2]   = dz[DetW-1] ^ d[DetW-1];
    cell_nxt.lane[0] = '{rem: '0, num: {mag(dx), 16'h0}, quo: '0};
    cell_nxt.lane[1] = '{rem: '0, num: {mag(dy), 16'h0}, quo: '0};
    cell_nxt.lane[2] = '{rem: '0, num: {mag(dz), 16'h0}, quo: '0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  assign out_vld  = vld2_r;
  assign out_cell = cell_r;

endmodule

>>> rtl/c3s_div_cell.sv
// ----------------------------------------------------------------------------
// c3s_div_cell: one restoring-division cell
// Resolves one quotient bit in each of three lanes and hands the item on.
// ----------------------------------------------------------------------------
module c3s_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  c3s_pkg::c3s_cell_t in_cell,
  output logic               out_vld,
  output c3s_pkg::c3s_cell_t out_cell
);
  import c3s_pkg::*;

  c3s_cell_t cell_r, cell_nxt;
  logic vld_r;

  always_comb begin
    logic [MagW:0] t;
    cell_nxt = in_cell;
    for (int l = 0; l < 3; l++) begin
      t = {in_cell.lane[l].rem[MagW-1:0], in_cell.lane[l].num[NumW-1]};
      cell_nxt.lane[l].num = {in_cell.lane[l].num[NumW-2:0], 1'b0};
      if (t >= {1'b0, in_cell.den}) begin
        cell_nxt.lane[l].rem = t - {1'b0, in_cell.den};
        cell_nxt.lane[l].quo = {in_cell.lane[l].quo[QW-2:0], 1'b1};
      end else begin
        cell_nxt.lane[l].rem = t;
        cell_nxt.lane[l].quo = {in_cell.lane[l].quo[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) cell_r <= cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (en) vld_r <= in_vld;
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;

endmodule
